// File: hdl/bpt_pkg.sv
// bpt_pkg: shared types for the box pruning test pipeline.
// No dependencies; imported by bpt_front, bpt_mul, bpt_acc and the top level.
package bpt_pkg;

  // Control that travels with one dimension down the pipeline.
  typedef struct packed {
    logic valid;
    logic last;
  } ctrl_t;

  // Widest operand the fixed-point multiplier takes after saturation.
  localparam int SAT_MAX_BITS = 32;

endpackage

// File: hdl/bpt_if.sv
// bpt_in_if / bpt_out_if: valid-ready channels of the box pruning test.
// Depends on nothing; used by the top level and the checker binding.
interface bpt_in_if #(
  parameter int COORD_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] cand_coord;
  logic signed [COORD_BITS-1:0] closest_coord;
  logic signed [COORD_BITS-1:0] box_low;
  logic signed [COORD_BITS-1:0] box_high;
  logic                         last_dim;

  modport source (
    output valid, cand_coord, closest_coord, box_low, box_high, last_dim,
    input  ready
  );
  modport sink (
    input  valid, cand_coord, closest_coord, box_low, box_high, last_dim,
    output ready
  );
endinterface

interface bpt_out_if ();
  logic valid;
  logic ready;
  logic too_far;

  modport source (output valid, too_far, input ready);
  modport sink (input valid, too_far, output ready);
endinterface

// File: hdl/bpt_front.sv
// bpt_front: input register, coordinate differences and operand saturation.
// Depends on bpt_pkg.
module bpt_front import bpt_pkg::*; #(
  parameter int COORD_BITS = 16,
  parameter int EXT_BITS   = 32,
  parameter int MUL_LIMIT  = 32767
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        advance,
  input  logic                                        in_valid,
  input  logic signed [COORD_BITS-1:0]                cand_coord,
  input  logic signed [COORD_BITS-1:0]                closest_coord,
  input  logic signed [COORD_BITS-1:0]                box_low,
  input  logic signed [COORD_BITS-1:0]                box_high,
  input  logic                                        last_dim,
  output ctrl_t                                       ctrl,
  output logic signed [((EXT_BITS < SAT_MAX_BITS) ? EXT_BITS : SAT_MAX_BITS)-1:0] c_sat,
  output logic signed [((EXT_BITS < SAT_MAX_BITS) ? EXT_BITS : SAT_MAX_BITS)-1:0] e_sat
);
  localparam int SAT_W = (EXT_BITS < SAT_MAX_BITS) ? EXT_BITS : SAT_MAX_BITS;
  localparam int CMP_W = (EXT_BITS > SAT_MAX_BITS) ? EXT_BITS : SAT_MAX_BITS;
  localparam logic signed [CMP_W-1:0] LIM_HI = CMP_W'(MUL_LIMIT);
  localparam logic signed [CMP_W-1:0] LIM_LO = ~LIM_HI;

  logic                         in_vld;
  logic                         last_r;
  logic signed [COORD_BITS-1:0] cand_r;
  logic signed [COORD_BITS-1:0] clos_r;
  logic signed [COORD_BITS-1:0] lo_r;
  logic signed [COORD_BITS-1:0] hi_r;

  logic signed [EXT_BITS-1:0] cand_e;
  logic signed [EXT_BITS-1:0] clos_e;
  logic signed [EXT_BITS-1:0] lo_e;
  logic signed [EXT_BITS-1:0] hi_e;
  logic signed [EXT_BITS-1:0] c_diff;
  logic signed [EXT_BITS-1:0] e_diff;

  function automatic logic signed [SAT_W-1:0] sat(input logic signed [EXT_BITS-1:0] v);
    logic signed [CMP_W-1:0] vw;
    logic signed [CMP_W-1:0] r;
    vw = CMP_W'(v);
    if (vw > LIM_HI) begin
      r = LIM_HI;
    end else if (vw < LIM_LO) begin
      r = LIM_LO;
    end else begin
      r = vw;
    end
    return SAT_W'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (advance) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cand_r <= cand_coord;
      clos_r <= closest_coord;
      lo_r   <= box_low;
      hi_r   <= box_high;
      last_r <= last_dim;
    end
  end

  always_comb begin
    cand_e = EXT_BITS'(cand_r);
    clos_e = EXT_BITS'(clos_r);
    lo_e   = EXT_BITS'(lo_r);
    hi_e   = EXT_BITS'(hi_r);
    c_diff = cand_e - clos_e;
    // positive offset looks at the far (high) face, otherwise the low face
    e_diff = ((c_diff > 0) ? hi_e : lo_e) - clos_e;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else if (advance) begin
      ctrl.valid <= in_vld;
      ctrl.last  <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c_sat <= sat(c_diff);
      e_sat <= sat(e_diff);
    end
  end

endmodule

// File: hdl/bpt_mul.sv
// bpt_mul: two fixed-point multiplies (c*c and e*c) with a result register.
// Depends on bpt_pkg.
module bpt_mul import bpt_pkg::*; #(
  parameter int EXT_BITS      = 32,
  parameter int MUL_FRAC_BITS = 6
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        advance,
  input  ctrl_t                                       ctrl_in,
  input  logic signed [((EXT_BITS < SAT_MAX_BITS) ? EXT_BITS : SAT_MAX_BITS)-1:0] c_sat,
  input  logic signed [((EXT_BITS < SAT_MAX_BITS) ? EXT_BITS : SAT_MAX_BITS)-1:0] e_sat,
  output ctrl_t                                       ctrl_out,
  output logic signed [EXT_BITS-1:0]                  prod_cc,
  output logic signed [EXT_BITS-1:0]                  prod_ec
);
  localparam int SAT_W  = (EXT_BITS < SAT_MAX_BITS) ? EXT_BITS : SAT_MAX_BITS;
  localparam int PROD_W = 2 * SAT_W;

  logic signed [PROD_W-1:0] full_cc;
  logic signed [PROD_W-1:0] full_ec;

  always_comb begin
    full_cc = PROD_W'(c_sat) * PROD_W'(c_sat);
    full_ec = PROD_W'(e_sat) * PROD_W'(c_sat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else if (advance) begin
      ctrl_out <= ctrl_in;
    end
  end

  // floor shift drops the fraction, then wrap to the accumulator width
  always_ff @(posedge clk) begin
    if (advance) begin
      prod_cc <= EXT_BITS'(full_cc >>> MUL_FRAC_BITS);
      prod_ec <= EXT_BITS'(full_ec >>> MUL_FRAC_BITS);
    end
  end

endmodule

// File: hdl/bpt_acc.sv
// bpt_acc: wrapping dot-product accumulators, final compare, result register.
// Depends on bpt_pkg.
module bpt_acc import bpt_pkg::*; #(
  parameter int EXT_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  ctrl_t                      ctrl,
  input  logic signed [EXT_BITS-1:0] prod_cc,
  input  logic signed [EXT_BITS-1:0] prod_ec,
  output logic                       res_valid,
  output logic                       too_far
);
  logic signed [EXT_BITS-1:0] center_dot_acc;
  logic signed [EXT_BITS-1:0] box_dot_acc;
  logic signed [EXT_BITS-1:0] center_next;
  logic signed [EXT_BITS-1:0] box_next;
  logic signed [EXT_BITS-1:0] box_dbl;
  logic                       take;

  always_comb begin
    take        = advance && ctrl.valid;
    center_next = center_dot_acc + prod_cc;
    box_next    = box_dot_acc + prod_ec;
    box_dbl     = box_next << 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      center_dot_acc <= '0;
      box_dot_acc    <= '0;
    end else if (take) begin
      if (ctrl.last) begin
        center_dot_acc <= '0;
        box_dot_acc    <= '0;
      end else begin
        center_dot_acc <= center_next;
        box_dot_acc    <= box_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= ctrl.valid && ctrl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (take && ctrl.last) begin
      too_far <= center_next > box_dbl;
    end
  end

endmodule

// File: hdl/kmeans_box_prune_test.sv
// kmeans_box_prune_test: pruning test of a candidate centre against a box.
// One dimension accepted per cycle unless a result waits unread; the result
// for a vector is valid at the output once its last dimension has passed the
// input, operand, product and result registers. The whole pipeline holds only
// while a result waits unread. Synchronous reset clears valids and both
// accumulators.
module kmeans_box_prune_test import bpt_pkg::*; #(
  parameter int COORD_BITS    = 16,
  parameter int EXT_BITS      = 32,
  parameter int MUL_FRAC_BITS = 6,
  parameter int MUL_LIMIT     = 32767
) (
  input  logic      clk,
  input  logic      rst,
  bpt_in_if.sink    item,
  bpt_out_if.source result
);
  localparam int SAT_W = (EXT_BITS < SAT_MAX_BITS) ? EXT_BITS : SAT_MAX_BITS;

  logic                       advance;
  logic                       res_valid;
  logic                       too_far;
  ctrl_t                      ctrl_op;
  ctrl_t                      ctrl_prod;
  logic signed [SAT_W-1:0]    c_sat;
  logic signed [SAT_W-1:0]    e_sat;
  logic signed [EXT_BITS-1:0] prod_cc;
  logic signed [EXT_BITS-1:0] prod_ec;

  // everything moves unless a finished result is held by the sink
  assign advance        = !(res_valid && !result.ready);
  assign item.ready     = advance;
  assign result.valid   = res_valid;
  assign result.too_far = too_far;

  bpt_front #(
    .COORD_BITS (COORD_BITS),
    .EXT_BITS   (EXT_BITS),
    .MUL_LIMIT  (MUL_LIMIT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .in_valid      (item.valid),
    .cand_coord    (item.cand_coord),
    .closest_coord (item.closest_coord),
    .box_low       (item.box_low),
    .box_high      (item.box_high),
    .last_dim      (item.last_dim),
    .ctrl          (ctrl_op),
    .c_sat         (c_sat),
    .e_sat         (e_sat)
  );

  bpt_mul #(
    .EXT_BITS      (EXT_BITS),
    .MUL_FRAC_BITS (MUL_FRAC_BITS)
  ) u_mul (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .ctrl_in  (ctrl_op),
    .c_sat    (c_sat),
    .e_sat    (e_sat),
    .ctrl_out (ctrl_prod),
    .prod_cc  (prod_cc),
    .prod_ec  (prod_ec)
  );

  bpt_acc #(
    .EXT_BITS (EXT_BITS)
  ) u_acc (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .ctrl      (ctrl_prod),
    .prod_cc   (prod_cc),
    .prod_ec   (prod_ec),
    .res_valid (res_valid),
    .too_far   (too_far)
  );

endmodule

// File: hdl/bpt_checker.sv
// bpt_checker: port-level assertions for kmeans_box_prune_test, and its bind.
// Depends on the top level's channel ports only.
module bpt_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic res_valid,
  input logic res_ready,
  input logic too_far
);
  logic stall;
  logic last_req;

  assign stall    = res_valid && !res_ready;
  assign last_req = in_valid && in_ready && in_last;

  // a held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    stall |=> res_valid && $stable(too_far))
    else $error("result changed while stalled");

  // input side stops exactly when the output side is blocked
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == !stall)
    else $error("input ready does not follow output stall");

  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  // a last-dimension request with a free pipeline yields a result
  a_latency: assert property (@(posedge clk) disable iff (rst)
    last_req ##1 !stall ##1 !stall ##1 !stall |=> res_valid)
    else $error("missing result after last dimension");

endmodule

bind kmeans_box_prune_test bpt_checker u_bpt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .in_last   (item.last_dim),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .too_far   (result.too_far)
);

// File: dv/tb.sv
// tb: self-checking bench for kmeans_box_prune_test, one box test per vector.
// Depends on bpt_in_if / bpt_out_if and the block itself; predicts
// too_far per vector and checks every returned request against it.
module tb;

  localparam int COORD_BITS    = 16;
  localparam int EXT_BITS      = 32;
  localparam int MUL_FRAC_BITS = 6;
  localparam int MUL_LIMIT     = 32767;
  localparam int LATENCY       = 3;
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [EXT_BITS-1:0]   ext_t;

  logic clk = 1'b0;
  logic rst;

  bpt_in_if #(.COORD_BITS(COORD_BITS)) item_ch ();
  bpt_out_if result_ch ();

  kmeans_box_prune_test #(
    .COORD_BITS   (COORD_BITS),
    .EXT_BITS     (EXT_BITS),
    .MUL_FRAC_BITS(MUL_FRAC_BITS),
    .MUL_LIMIT    (MUL_LIMIT)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // running dot products of the vector in flight, and verdicts not yet seen
  ext_t center_sum = '0;
  ext_t box_sum    = '0;
  bit   too_far_due[$];
  int   mismatches = 0;

  int src_idle_pct = 20;
  int dst_idle_pct = 63;
  bit hold_req     = 1'b0;
  int hold_left    = 0;
  int stall_cycles = 0;

  function automatic ext_t clamp_operand(ext_t v);
    ext_t top;
    top = ext_t'(MUL_LIMIT);
    if (v > top) return top;
    if (v < -top - 1) return -top - 1;
    return v;
  endfunction

  function automatic ext_t fixed_mul(ext_t a, ext_t b);
    logic signed [2*EXT_BITS-1:0] wa, wb, prod;
    wa   = clamp_operand(a);
    wb   = clamp_operand(b);
    prod = wa * wb;
    return ext_t'(prod >>> MUL_FRAC_BITS);
  endfunction

  always @(posedge clk) begin : scoreboard
    ext_t   diff, reach, doubled;
    coord_t bound;
    bit     due;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (too_far_due.size() == 0) begin
        $error("too_far: expected no request, got %0b", result_ch.too_far);
        mismatches++;
      end else begin
        due = too_far_due.pop_front();
        if (result_ch.too_far !== due) begin
          $error("too_far: expected %0b, got %0b", due, result_ch.too_far);
          mismatches++;
        end
      end
    end
    if (!rst && item_ch.valid && item_ch.ready) begin
      diff  = ext_t'(item_ch.cand_coord) - ext_t'(item_ch.closest_coord);
      // zero difference takes the low bound
      bound = (diff > 0) ? item_ch.box_high : item_ch.box_low;
      reach = ext_t'(bound) - ext_t'(item_ch.closest_coord);
      center_sum = center_sum + fixed_mul(diff, diff);
      box_sum    = box_sum + fixed_mul(reach, diff);
      if (item_ch.last_dim) begin
        doubled = box_sum << 1;
        too_far_due.push_back(center_sum > doubled);
        center_sum = '0;
        box_sum    = '0;
      end
    end
  end

  // receiver; a requested hold-off is counted down here
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      result_ch.ready = 1'b0;
      hold_left--;
    end else begin
      result_ch.ready = ($urandom_range(99) >= dst_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_dim(input int cand, input int clos, input int lo, input int hi,
                          input bit last);
    if ($urandom_range(99) < src_idle_pct) begin
      item_ch.valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    item_ch.valid         = 1'b1;
    item_ch.cand_coord    = coord_t'(cand);
    item_ch.closest_coord = coord_t'(clos);
    item_ch.box_low       = coord_t'(lo);
    item_ch.box_high      = coord_t'(hi);
    item_ch.last_dim      = last;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    item_ch.valid = 1'b0;
    while (too_far_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic int fit_coord(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int rand_coord();
    int corner[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    int kind;
    kind = $urandom_range(9);
    if (kind < 4) return int'($urandom_range(65535)) - 32768;
    if (kind < 6) return corner[$urandom_range(6)];
    return int'($urandom_range(4000)) - 2000;
  endfunction

  task automatic test_directed();
    send_dim(0, 0, 0, 0, 1'b1);
    // differences beyond the multiplier limit saturate
    send_dim(32767, -32768, -32768, 32767, 1'b1);
    send_dim(-32768, 32767, -32768, 32767, 1'b1);
    // zero difference
    send_dim(100, 100, -5000, 5000, 1'b1);
    // inverted box
    send_dim(1000, 0, 300, -300, 1'b1);
    // candidate well outside the box
    send_dim(20000, 0, -100, 100, 1'b0);
    send_dim(15000, 0, -100, 100, 1'b1);
    // candidate inside the box
    send_dim(50, 0, -100, 100, 1'b0);
    send_dim(-40, 0, -100, 100, 1'b1);
    // shift rounds toward minus infinity
    send_dim(-3, 0, -1, 1, 1'b1);
    send_dim(1, 0, -5, -7, 1'b1);
    send_dim(-1, -1, -1, -1, 1'b1);
    send_dim('h5555, 'hAAAA, 'hAAAA, 'h5555, 1'b0);
    send_dim('hAAAA, 'h5555, 'h5555, 'hAAAA, 1'b1);
    send_dim(32767, 32767, -32768, -32768, 1'b0);
    send_dim(-32768, -32768, 32767, 32767, 1'b1);
  endtask

  // long saturated vectors push the sums and the doubling past 32 bits
  task automatic test_accumulator_wrap();
    int dims[2] = '{70, 140};
    foreach (dims[v]) begin
      for (int d = 0; d < dims[v]; d++) begin
        if ($urandom_range(1))
          send_dim(32767, -32768, -32768, 32767, d == dims[v] - 1);
        else
          send_dim(-32768, 32767, -32768, 32767, d == dims[v] - 1);
      end
    end
  endtask

  task automatic test_random_vectors(input int count);
    int sent, dims, lo, hi, clos, cand;
    bit noise;
    sent = 0;
    while (sent < count) begin
      noise = ($urandom_range(99) < 15);
      dims  = ($urandom_range(9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 16);
      for (int d = 0; d < dims; d++) begin
        if (noise) begin
          // raw fields, random vector ends
          send_dim(int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768,
                   int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768,
                   $urandom_range(3) == 0);
        end else begin
          lo   = rand_coord();
          hi   = fit_coord(lo + int'($urandom_range(1) ? $urandom_range(300)
                                                        : $urandom_range(40000)));
          clos = lo + int'($urandom_range(hi - lo));
          if ($urandom_range(1))
            cand = fit_coord(clos + int'($urandom_range(2000)) - 1000);
          else
            cand = rand_coord();
          send_dim(cand, clos, lo, hi, d == dims - 1);
        end
        sent++;
      end
    end
  endtask

  // receiver stalls while short vectors keep arriving; the input must back up
  task automatic test_output_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 60; i++)
      send_dim(rand_coord(), rand_coord(), rand_coord(), rand_coord(), i[0]);
  endtask

  task automatic test_drain_pause();
    for (int r = 0; r < 3; r++) begin
      for (int i = 0; i < 10; i++)
        send_dim(rand_coord(), rand_coord(), rand_coord(), rand_coord(), i % 3 == 2);
      wait_drained();
    end
  endtask

  initial begin
    rst                   = 1'b1;
    item_ch.valid         = 1'b0;
    item_ch.cand_coord    = '0;
    item_ch.closest_coord = '0;
    item_ch.box_low       = '0;
    item_ch.box_high      = '0;
    item_ch.last_dim      = 1'b0;
    result_ch.ready       = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_accumulator_wrap();
    test_random_vectors(280);
    src_idle_pct = 63;
    dst_idle_pct = 20;
    test_random_vectors(280);
    test_output_backpressure();
    test_drain_pause();
    src_idle_pct = 0;
    dst_idle_pct = 0;
    test_random_vectors(280);
    wait_drained();

    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
